// ===== rtl/core/dttfp_pkg.sv =====
`default_nettype none

package dttfp_pkg;

  // Field and storage widths
  localparam int VALUE_W    = 64;
  localparam int MAG_W      = 63;
  localparam int POW_W      = 30;
  localparam int SCALE_W    = 4;
  localparam int ERR_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // Largest supported number of fraction digits
  localparam int MAX_SCALE = 9;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRACTION_DIGITS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEGATIVE_ALLOWED = 1'd1;

  // Register reset values
  localparam logic [SCALE_W-1:0] FRACTION_DIGITS_RESET = 4'd2;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY    = 3'd1;
  localparam logic [ERR_W-1:0] ERR_MISSING  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_INVALID  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_NEGATIVE = 3'd4;
  localparam logic [ERR_W-1:0] ERR_TOO_MANY = 3'd5;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'd6;

  // Character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] scaled_value;
    logic [ERR_W-1:0]          error_code;
  } result_t;

  // Parse outcome of one text, with the scaling still to be done
  typedef struct packed {
    logic [ERR_W-1:0]   pre_err;     // final error known before scaling
    logic [ERR_W-1:0]   post_err;    // error if scaling does not overflow
    logic               is_negative;
    logic [MAG_W-1:0]   magnitude;   // unscaled integer part
    logic [SCALE_W-1:0] int_scale;   // scale in force when the integer run closed
    logic               add_frac;
    logic [POW_W-1:0]   frac_acc;
    logic [SCALE_W-1:0] frac_shift;  // padding digits for the fraction
  } snap_t;

  // Power of ten for a digit count up to nine
  function automatic logic [POW_W-1:0] pow10(input logic [SCALE_W-1:0] n);
    logic [POW_W-1:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dttfp_parse.sv =====
`default_nettype none

module dttfp_parse #(
  parameter int MAX_SCALE = dttfp_pkg::MAX_SCALE
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              take,
  input  wire dttfp_pkg::in_item_t               item,
  input  wire logic [dttfp_pkg::SCALE_W-1:0]     fraction_digits,
  input  wire logic                              negative_allowed,
  output dttfp_pkg::snap_t                       snap,
  output logic                                   fire
);

  localparam int ACC_W = $clog2(10 ** MAX_SCALE);
  localparam logic [dttfp_pkg::SCALE_W-1:0] SCALE_CAP = dttfp_pkg::SCALE_W'(MAX_SCALE);

  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_NEED_INT = 3'd1;
  localparam logic [2:0] PH_INT      = 3'd2;
  localparam logic [2:0] PH_FRAC     = 3'd3;
  localparam logic [2:0] PH_DONE     = 3'd4;

  logic [2:0]                        phase, phase_next;
  logic [dttfp_pkg::MAG_W-1:0]       magnitude, magnitude_next;
  logic [ACC_W-1:0]                  frac_acc, frac_acc_next;
  logic [3:0]                        frac_count, frac_count_next;
  logic                              is_negative, is_negative_next;
  logic [dttfp_pkg::ERR_W-1:0]       pre_err, pre_err_next;
  logic [dttfp_pkg::ERR_W-1:0]       post_err, post_err_next;
  logic [dttfp_pkg::SCALE_W-1:0]     int_scale, int_scale_next;
  logic                              add_frac, add_frac_next;
  logic [dttfp_pkg::SCALE_W-1:0]     frac_shift, frac_shift_next;

  logic [dttfp_pkg::SCALE_W-1:0]     scale;
  logic                              num_char;
  logic [3:0]                        digit;
  logic [dttfp_pkg::MAG_W+3:0]       int_sum;
  logic                              int_ovf;
  logic [ACC_W+3:0]                  acc_sum;

  // Clamp the scale and decode the byte
  always_comb begin
    scale    = (fraction_digits > SCALE_CAP) ? SCALE_CAP : fraction_digits;
    num_char = item.char_code inside {[dttfp_pkg::CHAR_ZERO:dttfp_pkg::CHAR_NINE]};
    digit    = num_char ? 4'(item.char_code - dttfp_pkg::CHAR_ZERO) : 4'd0;
    int_sum  = (dttfp_pkg::MAG_W + 4)'({magnitude, 3'b000})
             + (dttfp_pkg::MAG_W + 4)'({magnitude, 1'b0})
             + (dttfp_pkg::MAG_W + 4)'(digit);
    int_ovf  = |int_sum[dttfp_pkg::MAG_W+3:dttfp_pkg::MAG_W];
    acc_sum  = (ACC_W + 4)'({frac_acc, 3'b000}) + (ACC_W + 4)'({frac_acc, 1'b0})
             + (ACC_W + 4)'(digit);
  end

  // Take the byte first, then the end of text
  always_comb begin
    phase_next       = phase;
    magnitude_next   = magnitude;
    frac_acc_next    = frac_acc;
    frac_count_next  = frac_count;
    is_negative_next = is_negative;
    pre_err_next     = pre_err;
    post_err_next    = post_err;
    int_scale_next   = int_scale;
    add_frac_next    = add_frac;
    frac_shift_next  = frac_shift;

    if (item.has_char) begin
      if (phase == PH_START && item.char_code == dttfp_pkg::CHAR_MINUS) begin
        if (!negative_allowed) begin
          pre_err_next = dttfp_pkg::ERR_NEGATIVE;
          phase_next   = PH_DONE;
        end else begin
          is_negative_next = 1'b1;
          phase_next       = PH_NEED_INT;
        end
      end else if (phase == PH_START || phase == PH_NEED_INT) begin
        if (!num_char) begin
          pre_err_next = dttfp_pkg::ERR_MISSING;
          phase_next   = PH_DONE;
        end else if (int_ovf) begin
          pre_err_next = dttfp_pkg::ERR_OVERFLOW;
          phase_next   = PH_DONE;
        end else begin
          magnitude_next = int_sum[dttfp_pkg::MAG_W-1:0];
          phase_next     = PH_INT;
        end
      end else if (phase == PH_INT) begin
        if (num_char) begin
          if (int_ovf) begin
            pre_err_next = dttfp_pkg::ERR_OVERFLOW;
            phase_next   = PH_DONE;
          end else begin
            magnitude_next = int_sum[dttfp_pkg::MAG_W-1:0];
          end
        end else begin
          int_scale_next = scale;
          if (item.char_code == dttfp_pkg::CHAR_POINT) begin
            phase_next = PH_FRAC;
          end else begin
            post_err_next = dttfp_pkg::ERR_INVALID;
            phase_next    = PH_DONE;
          end
        end
      end else if (phase == PH_FRAC) begin
        if (num_char) begin
          if (frac_count < SCALE_CAP) begin
            frac_acc_next = acc_sum[ACC_W-1:0];
          end
          if (frac_count != 4'd15) begin
            frac_count_next = frac_count + 4'd1;
          end
        end else begin
          phase_next = PH_DONE;
          if (frac_count == 4'd0) begin
            post_err_next = dttfp_pkg::ERR_MISSING;
          end else if (frac_count > scale) begin
            post_err_next = dttfp_pkg::ERR_TOO_MANY;
          end else begin
            add_frac_next   = 1'b1;
            frac_shift_next = scale - frac_count;
            post_err_next   = dttfp_pkg::ERR_INVALID;
          end
        end
      end
    end

    if (item.end_of_text) begin
      case (phase_next)
        PH_START: begin
          pre_err_next = dttfp_pkg::ERR_EMPTY;
        end
        PH_NEED_INT: begin
          pre_err_next = dttfp_pkg::ERR_MISSING;
        end
        PH_INT: begin
          int_scale_next = scale;
          post_err_next  = dttfp_pkg::ERR_NONE;
        end
        PH_FRAC: begin
          if (frac_count_next == 4'd0) begin
            post_err_next = dttfp_pkg::ERR_MISSING;
          end else if (frac_count_next > scale) begin
            post_err_next = dttfp_pkg::ERR_TOO_MANY;
          end else begin
            add_frac_next   = 1'b1;
            frac_shift_next = scale - frac_count_next;
            post_err_next   = dttfp_pkg::ERR_NONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hand the finished text to the scaling pipeline
  always_comb begin
    fire             = take && item.end_of_text;
    snap.pre_err     = pre_err_next;
    snap.post_err    = post_err_next;
    snap.is_negative = is_negative_next;
    snap.magnitude   = magnitude_next;
    snap.int_scale   = int_scale_next;
    snap.add_frac    = add_frac_next;
    snap.frac_acc    = dttfp_pkg::POW_W'(frac_acc_next);
    snap.frac_shift  = frac_shift_next;
  end

  // Advance the parse state; clear it at the end of each text
  always_ff @(posedge clk) begin
    if (rst || fire) begin
      phase       <= PH_START;
      magnitude   <= '0;
      frac_acc    <= '0;
      frac_count  <= '0;
      is_negative <= 1'b0;
      pre_err     <= dttfp_pkg::ERR_NONE;
      post_err    <= dttfp_pkg::ERR_NONE;
      int_scale   <= '0;
      add_frac    <= 1'b0;
      frac_shift  <= '0;
    end else if (take) begin
      phase       <= phase_next;
      magnitude   <= magnitude_next;
      frac_acc    <= frac_acc_next;
      frac_count  <= frac_count_next;
      is_negative <= is_negative_next;
      pre_err     <= pre_err_next;
      post_err    <= post_err_next;
      int_scale   <= int_scale_next;
      add_frac    <= add_frac_next;
      frac_shift  <= frac_shift_next;
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    fire |=> phase == PH_START && magnitude == '0 && pre_err == dttfp_pkg::ERR_NONE)
    else $error("parse state not cleared after end of text");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    take && !item.end_of_text && phase == PH_DONE |=> $stable(magnitude) && $stable(post_err))
    else $error("closed text changed its parse state");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/dttfp_scale.sv =====
`default_nettype none

module dttfp_scale (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              snap_valid,
  input  wire dttfp_pkg::snap_t  snap,
  output logic                   snap_ready,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dttfp_pkg::result_t     out_data
);

  localparam int LO_W = 32;
  localparam int HI_W = dttfp_pkg::MAG_W - LO_W;

  typedef struct packed {
    logic [dttfp_pkg::ERR_W-1:0] pre_err;
    logic [dttfp_pkg::ERR_W-1:0] post_err;
    logic                        is_negative;
  } tag_t;

  typedef struct packed {
    tag_t                        tag;
    logic [dttfp_pkg::MAG_W-1:0] magnitude;
    logic [dttfp_pkg::POW_W-1:0] p_int;
    logic [dttfp_pkg::POW_W-1:0] frac_acc;
    logic [dttfp_pkg::POW_W-1:0] p_frac;
  } lookup_t;

  typedef struct packed {
    tag_t                          tag;
    logic [LO_W+dttfp_pkg::POW_W-1:0]     lo_prod;
    logic [HI_W+dttfp_pkg::POW_W-1:0]     hi_prod;
    logic [2*dttfp_pkg::POW_W-1:0]        frac_prod;
  } mult_t;

  typedef struct packed {
    tag_t                          tag;
    logic                          int_ovf;
    logic [dttfp_pkg::MAG_W-1:0]   int_value;
    logic [2*dttfp_pkg::POW_W-1:0] frac_prod;
  } comb_t;

  typedef struct packed {
    logic                          is_negative;
    logic [dttfp_pkg::ERR_W-1:0]   err;
    logic [dttfp_pkg::MAG_W-1:0]   total;
  } sum_t;

  logic    v1, v2, v3, v4;
  lookup_t s1;
  mult_t   s2, s2_next;
  comb_t   s3, s3_next;
  sum_t    s4, s4_next;
  dttfp_pkg::result_t out_next;

  logic out_free, free4, free3, free2, free1;
  logic [HI_W+dttfp_pkg::POW_W:0] upper;
  logic [dttfp_pkg::VALUE_W-1:0]  total_sum;

  // Stage occupancy: a stage may load when it is empty or draining
  always_comb begin
    out_free   = !out_valid || !out_stall;
    free4      = !v4 || out_free;
    free3      = !v3 || free4;
    free2      = !v2 || free3;
    free1      = !v1 || free2;
    snap_ready = free1;
  end

  // Partial products of the scaling multiplies
  always_comb begin
    s2_next.tag       = s1.tag;
    s2_next.lo_prod   = (LO_W + dttfp_pkg::POW_W)'(s1.magnitude[LO_W-1:0])
                      * (LO_W + dttfp_pkg::POW_W)'(s1.p_int);
    s2_next.hi_prod   = (HI_W + dttfp_pkg::POW_W)'(s1.magnitude[dttfp_pkg::MAG_W-1:LO_W])
                      * (HI_W + dttfp_pkg::POW_W)'(s1.p_int);
    s2_next.frac_prod = (2 * dttfp_pkg::POW_W)'(s1.frac_acc)
                      * (2 * dttfp_pkg::POW_W)'(s1.p_frac);
  end

  // Combine the integer partial products and check the scaled range
  always_comb begin
    upper             = (HI_W + dttfp_pkg::POW_W + 1)'(s2.hi_prod)
                      + (HI_W + dttfp_pkg::POW_W + 1)'(s2.lo_prod[LO_W+dttfp_pkg::POW_W-1:LO_W]);
    s3_next.tag       = s2.tag;
    s3_next.int_ovf   = |upper[HI_W+dttfp_pkg::POW_W:HI_W];
    s3_next.int_value = {upper[HI_W-1:0], s2.lo_prod[LO_W-1:0]};
    s3_next.frac_prod = s2.frac_prod;
  end

  // Add the padded fraction and settle the error code
  always_comb begin
    total_sum           = dttfp_pkg::VALUE_W'(s3.int_value)
                        + dttfp_pkg::VALUE_W'(s3.frac_prod);
    s4_next.is_negative = s3.tag.is_negative;
    s4_next.total       = total_sum[dttfp_pkg::MAG_W-1:0];
    if (s3.tag.pre_err != dttfp_pkg::ERR_NONE) begin
      s4_next.err = s3.tag.pre_err;
    end else if (s3.int_ovf || total_sum[dttfp_pkg::VALUE_W-1]) begin
      s4_next.err = dttfp_pkg::ERR_OVERFLOW;
    end else begin
      s4_next.err = s3.tag.post_err;
    end
  end

  // Apply the sign, or zero on error
  always_comb begin
    out_next.error_code = s4.err;
    if (s4.err != dttfp_pkg::ERR_NONE) begin
      out_next.scaled_value = '0;
    end else if (s4.is_negative) begin
      out_next.scaled_value = -$signed(dttfp_pkg::VALUE_W'(s4.total));
    end else begin
      out_next.scaled_value = $signed(dttfp_pkg::VALUE_W'(s4.total));
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= (snap_valid && free1) || (v1 && !free2);
      v2        <= (v1 && free2) || (v2 && !free3);
      v3        <= (v2 && free3) || (v3 && !free4);
      v4        <= (v3 && free4) || (v4 && !out_free);
      out_valid <= (v4 && out_free) || (out_valid && out_stall);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (snap_valid && free1) begin
      s1.tag.pre_err     <= snap.pre_err;
      s1.tag.post_err    <= snap.post_err;
      s1.tag.is_negative <= snap.is_negative;
      s1.magnitude       <= snap.magnitude;
      s1.p_int           <= dttfp_pkg::pow10(snap.int_scale);
      s1.frac_acc        <= snap.frac_acc;
      s1.p_frac          <= snap.add_frac ? dttfp_pkg::pow10(snap.frac_shift) : '0;
    end
    if (v1 && free2) begin
      s2 <= s2_next;
    end
    if (v2 && free3) begin
      s3 <= s3_next;
    end
    if (v3 && free4) begin
      s4 <= s4_next;
    end
    if (v4 && out_free) begin
      out_data <= out_next;
    end
  end

`ifndef ASSERT_OFF
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error_code != dttfp_pkg::ERR_NONE |-> out_data.scaled_value == '0)
    else $error("nonzero value with an error code");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !free2 |=> v1 && $stable(s1))
    else $error("blocked lookup stage lost its contents");

  a_ovf_code: assert property (@(posedge clk) disable iff (rst)
    v3 && free4 && s3.tag.pre_err == dttfp_pkg::ERR_NONE && s3.int_ovf
      |=> s4.err == dttfp_pkg::ERR_OVERFLOW)
    else $error("integer scaling overflow not reported");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/decimal_text_to_fixed_point_unit.sv =====
`default_nettype none

// Decimal text to fixed-point converter. Each input beat carries at most one ASCII byte of a
// number (optional minus, integer digits, optional point and fraction digits); the beat with
// end_of_text set closes the number and produces one result beat with the value times ten to
// fraction_digits (capped at MAX_SCALE) as a signed 64-bit integer and an error code, the value
// being zero on any error. One byte is taken every cycle while in_stall is low; the per-byte
// multiply-by-ten and add, range-checked on the 63-bit magnitude, is the only input-path
// work. Results pass a four-stage scaling pipeline (table lookup, 32x30, 31x30 and 30x30
// multiplies, combine, fraction add) and an output register; up to five results queue there
// while the output is stalled, bytes flowing until full. Configuration must be written
// through cfg_write/cfg_index/cfg_data only while no text is in progress; not enforced.
module decimal_text_to_fixed_point_unit #(
  parameter int MAX_SCALE = dttfp_pkg::MAX_SCALE
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire dttfp_pkg::in_item_t                 in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output dttfp_pkg::result_t                       out_data,
  input  wire logic                                cfg_write,
  input  wire logic [dttfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dttfp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [dttfp_pkg::SCALE_W-1:0] fraction_digits;
  logic                          negative_allowed;
  logic                          snap_ready;
  logic                          take;
  logic                          fire;
  dttfp_pkg::snap_t              snap;

  // Accept a byte beat whenever the scaling pipeline can take a result
  always_comb begin
    in_stall = !snap_ready;
    take     = in_valid && snap_ready;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fraction_digits  <= dttfp_pkg::FRACTION_DIGITS_RESET;
      negative_allowed <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        dttfp_pkg::REG_FRACTION_DIGITS:  fraction_digits  <= cfg_data[dttfp_pkg::SCALE_W-1:0];
        dttfp_pkg::REG_NEGATIVE_ALLOWED: negative_allowed <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  dttfp_parse #(
    .MAX_SCALE (MAX_SCALE)
  ) u_parse (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .item             (in_data),
    .fraction_digits  (fraction_digits),
    .negative_allowed (negative_allowed),
    .snap             (snap),
    .fire             (fire)
  );

  dttfp_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (fire),
    .snap       (snap),
    .snap_ready (snap_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
